// ===== rtl/aging_keyed_event_table_unit_assert.svh =====
// assertion macros shared by the rtl, clocked on clk and quiet while arst_n is low
`ifndef AGING_KEYED_EVENT_TABLE_UNIT_ASSERT_SVH
`define AGING_KEYED_EVENT_TABLE_UNIT_ASSERT_SVH

// condition must hold in the same cycle as the trigger
`define AKET_ASSERT_NOW(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

// condition must hold in the cycle after the trigger
`define AKET_ASSERT_NEXT(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

// ===== rtl/aket_pkg.sv =====
package aket_pkg;

	// command codes carried in s_tuser
	typedef enum logic [1:0] {
		CMD_EXPIRE = 2'd0,
		CMD_RECORD = 2'd1,
		CMD_QUERY  = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_SCAN = 2'd1,
		ST_FIN  = 2'd2,
		ST_OUT  = 2'd3
	} state_t;

	localparam int unsigned ID_W    = 16;
	localparam int unsigned SIDE_W  = 2;
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned COUNT_W = 5;

	localparam int unsigned S_TDATA_W = 56;
	localparam int unsigned M_TDATA_W = 48;

	localparam logic [TIME_W-1:0] MEM_TIME_RESET = 32'd10000;

endpackage

// ===== rtl/aging_keyed_event_table_unit.sv =====
// Keyed event table with aging. Holds up to ENTRIES records (key, timestamp, side) in
// insertion order in a single-port-read, single-port-write memory. s_tuser selects the
// command: expire drops every record whose memory_time + stamp (33-bit, no wrap) is below
// now and compacts the survivors in order; record overwrites the record with the same key
// or appends a new one (a new key on a full table is dropped and flagged); query reports
// whether the key is present; code 3 changes nothing. Every transfer in gives exactly one
// transfer out with the latest stamp (first record wins on ties, zero stamps never win),
// its side and the record count after the command. A single sequencer walks the table
// once, one memory read per cycle, with one shared compare datapath evaluating each
// registered read record (age check, key match, latest stamp) up to the last registered
// read; ST_FIN then does the append/count update and ST_OUT loads the output register.
// ST_OUT repeats while the output register still holds an earlier result that m_tready
// has not taken. s_tready is low from acceptance until the output register is loaded,
// so a new item is taken only once the previous one is through the table. The output
// register lets the next item be accepted while the previous result still waits on
// m_tready. memory_time is written through cfg_wr_en / cfg_wr_data; the user must write
// it only while the block is idle, the block itself does not enforce this. It resets to
// 10000. No clearing pass after reset: records beyond the count are never read.
module aging_keyed_event_table_unit #(
	parameter int unsigned ENTRIES  = 16,
	parameter int unsigned KEY_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write: memory_time
	input  logic                           cfg_wr_en,
	input  logic [aket_pkg::TIME_W-1:0]    cfg_wr_data,
	// command input
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// [15:0] object_id, [17:16] hit_side, [49:18] now, [55:50] zero
	input  logic [aket_pkg::S_TDATA_W-1:0] s_tdata,
	// [1:0] command
	input  logic [1:0]                     s_tuser,
	// result output
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [0] found, [1] dropped, [33:2] latest_time, [35:34] latest_side,
	// [40:36] entry_count, [47:41] zero
	output logic [aket_pkg::M_TDATA_W-1:0] m_tdata
);

	import aket_pkg::*;

	// address and count widths follow the table depth
	localparam int unsigned AW = $clog2(ENTRIES);
	localparam int unsigned CW = $clog2(ENTRIES + 1);
	// only the low KEY_BITS of the 16-bit id take part in matching
	localparam int unsigned KW = (KEY_BITS < ID_W) ? KEY_BITS : ID_W;
	localparam logic [CW-1:0] FULL = CW'(ENTRIES);

	// record memory
	logic [KW-1:0]     key_mem   [ENTRIES];
	logic [TIME_W-1:0] stamp_mem [ENTRIES];
	logic [SIDE_W-1:0] side_mem  [ENTRIES];

	// control state
	state_t            state_q, state_d;
	logic [TIME_W-1:0] mem_time_q;
	logic [CW-1:0]     cnt_q;
	logic [CW-1:0]     rd_q;
	logic [CW-1:0]     wr_q;
	logic              dv_s1;
	logic              out_valid_q;

	// latched command
	cmd_t              cmd_q;
	logic [KW-1:0]     key_q;
	logic [SIDE_W-1:0] side_q;
	logic [TIME_W-1:0] now_q;

	// scan results
	logic              hit_q;
	logic              dropped_q;
	logic [TIME_W-1:0] best_q;
	logic [SIDE_W-1:0] bside_q;

	// read stage
	logic [KW-1:0]     rkey_s1;
	logic [TIME_W-1:0] rstamp_s1;
	logic [SIDE_W-1:0] rside_s1;
	logic [AW-1:0]     ridx_s1;

	// output register
	logic              out_found_q;
	logic              out_dropped_q;
	logic [TIME_W-1:0] out_time_q;
	logic [SIDE_W-1:0] out_side_q;
	logic [COUNT_W-1:0] out_cnt_q;

	// sequencer strobes and shared datapath
	logic              accept;
	logic              issue;
	logic              proc;
	logic              match;
	logic              keep;
	logic [TIME_W:0]   limit;
	logic [TIME_W-1:0] cand_stamp;
	logic [SIDE_W-1:0] cand_side;
	logic              cand_take;
	logic              can_append;
	logic              append;
	logic              out_load;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [KW-1:0]     mem_wkey;
	logic [TIME_W-1:0] mem_wstamp;
	logic [SIDE_W-1:0] mem_wside;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// shared compare datapath on the record coming out of the read stage
	always_comb begin
		limit = {1'b0, mem_time_q} + {1'b0, rstamp_s1};
		keep  = !(limit < {1'b0, now_q});
		match = (rkey_s1 == key_q);
		cand_stamp = rstamp_s1;
		cand_side  = rside_s1;
		// an overwritten record competes with its new stamp
		if (cmd_q == CMD_RECORD && match) begin
			cand_stamp = now_q;
			cand_side  = side_q;
		end
		cand_take = (cand_stamp > best_q) && !(cmd_q == CMD_EXPIRE && !keep);
	end

	// sequencer: next state and strobes
	always_comb begin
		state_d    = state_q;
		issue      = 1'b0;
		proc       = 1'b0;
		append     = 1'b0;
		out_load   = 1'b0;
		mem_we     = 1'b0;
		mem_waddr  = ridx_s1;
		mem_wkey   = key_q;
		mem_wstamp = now_q;
		mem_wside  = side_q;
		can_append = (cnt_q < FULL);
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				issue = (rd_q < cnt_q);
				proc  = dv_s1;
				if (dv_s1) begin
					if (cmd_q == CMD_EXPIRE && keep) begin
						// compact survivors down to the write pointer
						mem_we     = 1'b1;
						mem_waddr  = wr_q[AW-1:0];
						mem_wkey   = rkey_s1;
						mem_wstamp = rstamp_s1;
						mem_wside  = rside_s1;
					end else if (cmd_q == CMD_RECORD && match) begin
						// overwrite in place
						mem_we = 1'b1;
					end
				end
				if (!issue) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				append = (cmd_q == CMD_RECORD) && !hit_q && can_append;
				if (append) begin
					mem_we    = 1'b1;
					mem_waddr = cnt_q[AW-1:0];
				end
				state_d = ST_OUT;
			end
			ST_OUT: begin
				out_load = !out_valid_q || m_tready;
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			key_mem[mem_waddr]   <= mem_wkey;
			stamp_mem[mem_waddr] <= mem_wstamp;
			side_mem[mem_waddr]  <= mem_wside;
		end
		rkey_s1   <= key_mem[rd_q[AW-1:0]];
		rstamp_s1 <= stamp_mem[rd_q[AW-1:0]];
		rside_s1  <= side_mem[rd_q[AW-1:0]];
		ridx_s1   <= rd_q[AW-1:0];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_time_q  <= MEM_TIME_RESET;
			cnt_q       <= '0;
			rd_q        <= '0;
			wr_q        <= '0;
			dv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				mem_time_q <= cfg_wr_data;
			end
			if (accept) begin
				rd_q <= '0;
				wr_q <= '0;
			end
			dv_s1 <= issue;
			if (issue) begin
				rd_q <= rd_q + CW'(1);
			end
			if (proc && cmd_q == CMD_EXPIRE && keep) begin
				wr_q <= wr_q + CW'(1);
			end
			if (state_q == ST_FIN) begin
				if (cmd_q == CMD_EXPIRE) begin
					cnt_q <= wr_q;
				end else if (append) begin
					cnt_q <= cnt_q + CW'(1);
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// command latch, running results and output payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q     <= cmd_t'(s_tuser);
			key_q     <= s_tdata[KW-1:0];
			side_q    <= s_tdata[17:16];
			now_q     <= s_tdata[49:18];
			hit_q     <= 1'b0;
			dropped_q <= 1'b0;
			best_q    <= '0;
			bside_q   <= '0;
		end
		if (proc) begin
			if (match && (cmd_q == CMD_RECORD || cmd_q == CMD_QUERY)) begin
				hit_q <= 1'b1;
			end
			if (cand_take) begin
				best_q  <= cand_stamp;
				bside_q <= cand_side;
			end
		end
		if (state_q == ST_FIN) begin
			if (append && now_q > best_q) begin
				best_q  <= now_q;
				bside_q <= side_q;
			end
			dropped_q <= (cmd_q == CMD_RECORD) && !hit_q && !can_append;
		end
		if (out_load) begin
			out_found_q   <= (cmd_q == CMD_QUERY) && hit_q;
			out_dropped_q <= dropped_q;
			out_time_q    <= best_q;
			out_side_q    <= bside_q;
			out_cnt_q     <= COUNT_W'(cnt_q);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_cnt_q, out_side_q, out_time_q, out_dropped_q, out_found_q};

	`include "aging_keyed_event_table_unit_assert.svh"

	`AKET_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= FULL, "record count beyond table depth")
	`AKET_ASSERT_NOW(a_dv_in_scan, dv_s1, state_q == ST_SCAN, "read data outside the walk")
	`AKET_ASSERT_NEXT(a_accept_scan, accept, state_q == ST_SCAN, "accepted item not walked")
	`AKET_ASSERT_NOW(a_compact_order, state_q == ST_SCAN && cmd_q == CMD_EXPIRE,
		wr_q <= rd_q, "compaction overtook the read pointer")
	`AKET_ASSERT_NOW(a_flags_excl, out_valid_q, !(out_found_q && out_dropped_q),
		"found and dropped both set")

endmodule
